### rtl/core/smtu_pkg.sv
package smtu_pkg;

	// Field widths of the request and result items.
	localparam int IDX_W      = 7;
	localparam int POS_W      = 11;
	localparam int SPD_W      = 4;
	localparam int DLY_W      = 4;
	localparam int DIR_W      = 2;
	localparam int FRM_W      = 6;
	localparam int SPR_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// Request operations.
	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_UPDATE = 1'b1
	} opcode_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_TOP_MARGIN    = 3'd2,
		REG_SPRITE_WIDTH  = 3'd3,
		REG_SPRITE_HEIGHT = 3'd4,
		REG_MAX_FRAME     = 3'd5
	} reg_index_t;

	// Animation direction codes; any other code holds the frame.
	localparam logic [DIR_W-1:0] DIR_BACK = 2'b11;
	localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;

	// Register reset values.
	localparam logic [POS_W-1:0] RST_SCREEN_WIDTH  = 11'd640;
	localparam logic [POS_W-1:0] RST_SCREEN_HEIGHT = 11'd480;
	localparam logic [POS_W-1:0] RST_TOP_MARGIN    = 11'd40;
	localparam logic [SPR_W-1:0] RST_SPRITE_WIDTH  = 8'd64;
	localparam logic [SPR_W-1:0] RST_SPRITE_HEIGHT = 8'd64;
	localparam logic [FRM_W-1:0] RST_MAX_FRAME     = 6'd63;

	// One sprite table entry as stored in memory.
	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [SPD_W-1:0] sx;
		logic [SPD_W-1:0] sy;
		logic [DLY_W-1:0] dx;
		logic [DLY_W-1:0] dy;
		logic [DLY_W-1:0] df;
		logic [DLY_W-1:0] cx;
		logic [DLY_W-1:0] cy;
		logic [DLY_W-1:0] cf;
		logic [DIR_W-1:0] dir;
		logic [FRM_W-1:0] frame;
	} entry_t;

	// Configuration register set.
	typedef struct packed {
		logic [POS_W-1:0] screen_width;
		logic [POS_W-1:0] screen_height;
		logic [POS_W-1:0] top_margin;
		logic [SPR_W-1:0] sprite_width;
		logic [SPR_W-1:0] sprite_height;
		logic [FRM_W-1:0] max_frame;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic [IDX_W-1:0] out_index;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [FRM_W-1:0] frame;
	} result_t;

endpackage

### rtl/core/smtu_if.sv
// Request channel into the block.
interface smtu_in_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [smtu_pkg::IDX_W-1:0]  sprite_index;
	logic [smtu_pkg::POS_W-1:0]  load_x;
	logic [smtu_pkg::POS_W-1:0]  load_y;
	logic signed [smtu_pkg::SPD_W-1:0] speed_x;
	logic signed [smtu_pkg::SPD_W-1:0] speed_y;
	logic [smtu_pkg::DLY_W-1:0]  delay_x;
	logic [smtu_pkg::DLY_W-1:0]  delay_y;
	logic [smtu_pkg::DLY_W-1:0]  delay_frame;
	logic signed [smtu_pkg::DIR_W-1:0] direction;
	logic [smtu_pkg::FRM_W-1:0]  start_frame;

	modport source (
		output valid, opcode, sprite_index, load_x, load_y, speed_x, speed_y,
		       delay_x, delay_y, delay_frame, direction, start_frame,
		input  ready
	);
	modport sink (
		input  valid, opcode, sprite_index, load_x, load_y, speed_x, speed_y,
		       delay_x, delay_y, delay_frame, direction, start_frame,
		output ready
	);
endinterface

// Result channel out of the block.
interface smtu_out_if;
	logic                        valid;
	logic                        ready;
	logic [smtu_pkg::IDX_W-1:0]  out_index;
	logic [smtu_pkg::POS_W-1:0]  pos_x;
	logic [smtu_pkg::POS_W-1:0]  pos_y;
	logic [smtu_pkg::FRM_W-1:0]  frame;

	modport source (
		output valid, out_index, pos_x, pos_y, frame,
		input  ready
	);
	modport sink (
		input  valid, out_index, pos_x, pos_y, frame,
		output ready
	);
endinterface

### rtl/core/smtu_ram.sv
module smtu_ram #(
	parameter int WIDTH = 62,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; the read data holds
	// until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/smtu_update.sv
module smtu_update (
	input  smtu_pkg::entry_t cur,
	input  smtu_pkg::cfg_t   cfg,
	output smtu_pkg::entry_t nxt
);
	import smtu_pkg::*;

	localparam int SUM_W = POS_W + 2;

	logic [POS_W-1:0] lim_x;
	logic [POS_W-1:0] lim_y;
	logic [SUM_W-1:0] x_sum;
	logic [SUM_W-1:0] y_sum;
	logic             step_x;
	logic             step_y;
	logic             step_f;
	logic [FRM_W-1:0] frame_step;

	// Wrap limits: screen size less sprite size, floored at zero.
	always_comb begin
		lim_x = (cfg.screen_width > POS_W'(cfg.sprite_width))
		      ? cfg.screen_width - POS_W'(cfg.sprite_width) : '0;
		lim_y = (cfg.screen_height > POS_W'(cfg.sprite_height))
		      ? cfg.screen_height - POS_W'(cfg.sprite_height) : '0;
	end

	// A counter that has reached its delay rolls over and fires a step.
	assign step_x = (cur.cx >= cur.dx);
	assign step_y = (cur.cy >= cur.dy);
	assign step_f = (cur.cf >= cur.df);

	// Signed moves on both axes.
	always_comb begin
		x_sum = {2'b00, cur.x};
		y_sum = {2'b00, cur.y};
		if (step_x) begin
			x_sum = x_sum + {{(SUM_W-SPD_W){cur.sx[SPD_W-1]}}, cur.sx};
		end
		if (step_y) begin
			y_sum = y_sum + {{(SUM_W-SPD_W){cur.sy[SPD_W-1]}}, cur.sy};
		end
	end

	// Frame step with wrap at both ends.
	always_comb begin
		frame_step = cur.frame;
		case (cur.dir)
			DIR_BACK: frame_step = (cur.frame == '0) ? cfg.max_frame : cur.frame - 1'b1;
			DIR_FWD:  frame_step = (cur.frame >= cfg.max_frame) ? '0 : cur.frame + 1'b1;
			default:  frame_step = cur.frame;
		endcase
	end

	// New entry: counters, wrapped position and frame.
	always_comb begin
		nxt    = cur;
		nxt.cx = step_x ? '0 : cur.cx + 1'b1;
		nxt.cy = step_y ? '0 : cur.cy + 1'b1;
		nxt.cf = step_f ? '0 : cur.cf + 1'b1;
		if (step_f) begin
			nxt.frame = frame_step;
		end

		if (x_sum[SUM_W-1]) begin
			nxt.x = lim_x;
		end else if (x_sum[SUM_W-2:0] > {1'b0, lim_x}) begin
			nxt.x = '0;
		end else begin
			nxt.x = x_sum[POS_W-1:0];
		end

		if (y_sum[SUM_W-1] || (y_sum[SUM_W-2:0] < {1'b0, cfg.top_margin})) begin
			nxt.y = lim_y;
		end else if (y_sum[SUM_W-2:0] > {1'b0, lim_y}) begin
			nxt.y = cfg.top_margin;
		end else begin
			nxt.y = y_sum[POS_W-1:0];
		end
	end

endmodule

### rtl/core/sprite_motion_table_update_core.sv
// Sprite motion table. Each request is a load or an update of one entry of a
// table held in a single synchronous RAM (one write port, one registered read
// port). The block takes one request per cycle: the read is issued when the
// request is accepted, the entry is modified and written back when it leaves
// stage 1, and an update's result enters the output register at that same
// edge. Requests to the same entry in consecutive cycles are served from a
// forwarding register, so the rate stays one request per cycle; only a result
// left waiting in the output register stalls the input. Loads return no
// result, nor does any request whose index lies beyond the table. The table
// has no reset; an entry must be loaded before it is updated. Configuration
// registers may be written only while the block is idle.
module sprite_motion_table_update_core #(
	parameter int SPRITE_COUNT = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	smtu_in_if.sink                       in_ch,
	smtu_out_if.source                    out_ch,
	input  logic                          cfg_we,
	input  logic [smtu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smtu_pkg::CFG_DATA_W-1:0] cfg_data
);
	import smtu_pkg::*;

	localparam int ADDR_W    = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
	localparam int IDX_EXT_W = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
	localparam int ENTRY_W   = $bits(entry_t);

	cfg_t               cfg_q;
	logic               in_acc;
	logic               in_range;
	logic [IDX_EXT_W-1:0] idx_ext;
	entry_t             load_entry;

	logic               valid_s1;
	opcode_t            op_s1;
	logic [IDX_W-1:0]   index_s1;
	logic [ADDR_W-1:0]  addr_s1;
	entry_t             load_s1;
	logic               fwd_hit_s1;
	entry_t             fwd_data_s1;
	logic               adv_s1;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ADDR_W-1:0]  ram_raddr;
	entry_t             ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             cur_entry;
	entry_t             nxt_entry;

	logic               out_valid_q;
	result_t            result_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= RST_SCREEN_WIDTH;
			cfg_q.screen_height <= RST_SCREEN_HEIGHT;
			cfg_q.top_margin    <= RST_TOP_MARGIN;
			cfg_q.sprite_width  <= RST_SPRITE_WIDTH;
			cfg_q.sprite_height <= RST_SPRITE_HEIGHT;
			cfg_q.max_frame     <= RST_MAX_FRAME;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data;
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
				REG_TOP_MARGIN:    cfg_q.top_margin    <= cfg_data;
				REG_SPRITE_WIDTH:  cfg_q.sprite_width  <= cfg_data[SPR_W-1:0];
				REG_SPRITE_HEIGHT: cfg_q.sprite_height <= cfg_data[SPR_W-1:0];
				REG_MAX_FRAME:     cfg_q.max_frame     <= cfg_data[FRM_W-1:0];
				default: ;
			endcase
		end
	end

	// Request acceptance and index check.
	assign in_ch.ready = !valid_s1 || adv_s1;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign idx_ext     = IDX_EXT_W'(in_ch.sprite_index);
	assign in_range    = (idx_ext < IDX_EXT_W'(SPRITE_COUNT));
	assign ram_raddr   = idx_ext[ADDR_W-1:0];

	// Entry written by a load, with its counters cleared.
	always_comb begin
		load_entry.x     = in_ch.load_x;
		load_entry.y     = in_ch.load_y;
		load_entry.sx    = in_ch.speed_x;
		load_entry.sy    = in_ch.speed_y;
		load_entry.dx    = in_ch.delay_x;
		load_entry.dy    = in_ch.delay_y;
		load_entry.df    = in_ch.delay_frame;
		load_entry.cx    = '0;
		load_entry.cy    = '0;
		load_entry.cf    = '0;
		load_entry.dir   = in_ch.direction;
		load_entry.frame = in_ch.start_frame;
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= in_range;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload; the forwarding register catches a write-back to the
	// entry being read in the same cycle.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1       <= opcode_t'(in_ch.opcode);
			index_s1    <= in_ch.sprite_index;
			addr_s1     <= ram_raddr;
			load_s1     <= load_entry;
			fwd_hit_s1  <= ram_we && (ram_waddr == ram_raddr);
			fwd_data_s1 <= ram_wdata;
		end
	end

	// A load always retires; an update needs the output register free.
	assign adv_s1 = valid_s1 && ((op_s1 == OP_LOAD) || !out_valid_q || out_ch.ready);

	assign cur_entry = fwd_hit_s1 ? fwd_data_s1 : entry_t'(ram_rdata);

	smtu_update u_update (
		.cur (cur_entry),
		.cfg (cfg_q),
		.nxt (nxt_entry)
	);

	// Write-back of the loaded or updated entry.
	assign ram_we    = adv_s1;
	assign ram_waddr = addr_s1;
	assign ram_wdata = (op_s1 == OP_LOAD) ? load_s1 : nxt_entry;

	smtu_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SPRITE_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && (op_s1 == OP_UPDATE)) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv_s1 && (op_s1 == OP_UPDATE)) begin
			result_q.out_index <= index_s1;
			result_q.pos_x     <= nxt_entry.x;
			result_q.pos_y     <= nxt_entry.y;
			result_q.frame     <= nxt_entry.frame;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_index = result_q.out_index;
	assign out_ch.pos_x     = result_q.pos_x;
	assign out_ch.pos_y     = result_q.pos_y;
	assign out_ch.frame     = result_q.frame;

`ifndef SYNTHESIS
	// A stalled stage 1 must hold off new requests.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> !in_ch.ready)
		else $error("request accepted while stage 1 is stalled");

	// Every retired update shows up in the output register.
	a_update_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (op_s1 == OP_UPDATE)) |=> out_ch.valid)
		else $error("retired update produced no result");

	// A read that collides with a write-back must take the forwarded entry.
	a_forward_on_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && ram_we && (ram_waddr == ram_raddr)) |=> fwd_hit_s1)
		else $error("read of entry being written was not forwarded");
`endif

endmodule
